// ----- rtl/mss_pkg.sv -----
// Shared types, constants and helper functions of the step sequencer.
`timescale 1ns / 1ps
`default_nettype none
package mss_pkg;

  // Store geometry
  localparam int MAX_TRACKS = 8;
  localparam int MAX_STEPS  = 32;
  localparam int TRK_W      = $clog2(MAX_TRACKS);
  localparam int STP_W      = $clog2(MAX_STEPS);
  localparam int ADDR_W     = TRK_W + STP_W;
  localparam int DEPTH      = MAX_TRACKS * MAX_STEPS;

  // Field widths
  localparam int VAL_W   = 16;
  localparam int LEN_W   = 9;
  localparam int ENTRY_W = VAL_W + LEN_W;
  localparam int SPS_W   = 24;
  localparam int SCNT_W  = 6;
  localparam int TCNT_W  = 4;
  localparam int PROD_W  = LEN_W + SPS_W;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(128);
  localparam logic [SPS_W-1:0]  SPS_RESET  = SPS_W'(24000);
  localparam logic [SCNT_W-1:0] SCNT_RESET = SCNT_W'(8);
  localparam logic [TCNT_W-1:0] TCNT_RESET = TCNT_W'(1);
  localparam logic [SCNT_W-1:0] MIN_STEPS  = SCNT_W'(4);
  localparam logic [SPS_W-1:0]  ELAPSED_MAX = {SPS_W{1'b1}};

  // Register indexes (word address)
  localparam logic [1:0] REG_SPS  = 2'd0;
  localparam logic [1:0] REG_SCNT = 2'd1;
  localparam logic [1:0] REG_TCNT = 2'd2;
  localparam logic [1:0] REG_EXT  = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_WRITE   = 2'd2
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [SPS_W-1:0]  samples_per_step;
    logic [SCNT_W-1:0] step_count;
    logic [TCNT_W-1:0] track_count;
    logic              external_advance;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic issue;
    logic load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_req;
    logic scan_last;
    logic pipe_busy;
    logic mask_empty;
    logic mask_single;
    logic slot_free;
  } stat_t;

  // Index of the highest track in use
  function automatic logic [TRK_W-1:0] last_track(input logic [TCNT_W-1:0] tc);
    logic [TRK_W-1:0] r;
    if (tc == '0) begin
      r = '0;
    end else if (32'(tc) > MAX_TRACKS) begin
      r = TRK_W'(MAX_TRACKS - 1);
    end else begin
      r = TRK_W'(tc - TCNT_W'(1));
    end
    return r;
  endfunction

  // Number of steps in use, clamped to the legal range
  function automatic logic [SCNT_W-1:0] steps_in_use(input logic [SCNT_W-1:0] sc);
    logic [SCNT_W-1:0] r;
    if (sc < MIN_STEPS) begin
      r = MIN_STEPS;
    end else if (32'(sc) > MAX_STEPS) begin
      r = SCNT_W'(MAX_STEPS);
    end else begin
      r = sc;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/mss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mss_regs.sv -----
// APB configuration registers of the step sequencer.
`timescale 1ns / 1ps
`default_nettype none
module mss_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mss_pkg::APB_AW-1:0]   paddr,
  input  wire logic [mss_pkg::APB_DW-1:0]   pwdata,
  output logic      [mss_pkg::APB_DW-1:0]   prdata,
  output logic                              pready,
  output mss_pkg::cfg_t                     cfg_o,
  output logic                              scnt_wr_o
);

  mss_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Write registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.samples_per_step <= mss_pkg::SPS_RESET;
      cfg_q.step_count       <= mss_pkg::SCNT_RESET;
      cfg_q.track_count      <= mss_pkg::TCNT_RESET;
      cfg_q.external_advance <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        mss_pkg::REG_SPS:  cfg_q.samples_per_step <= pwdata[mss_pkg::SPS_W-1:0];
        mss_pkg::REG_SCNT: cfg_q.step_count       <= pwdata[mss_pkg::SCNT_W-1:0];
        mss_pkg::REG_TCNT: cfg_q.track_count      <= pwdata[mss_pkg::TCNT_W-1:0];
        mss_pkg::REG_EXT:  cfg_q.external_advance <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Flag a step count write so the position restarts
  assign scnt_wr_o = wr_en && (reg_idx == mss_pkg::REG_SCNT);

  // Read back
  always_comb begin
    case (reg_idx)
      mss_pkg::REG_SPS:  prdata = mss_pkg::APB_DW'(cfg_q.samples_per_step);
      mss_pkg::REG_SCNT: prdata = mss_pkg::APB_DW'(cfg_q.step_count);
      mss_pkg::REG_TCNT: prdata = mss_pkg::APB_DW'(cfg_q.track_count);
      mss_pkg::REG_EXT:  prdata = mss_pkg::APB_DW'(cfg_q.external_advance);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ----- rtl/mss_ctrl.sv -----
// Controller state machine: accept, scan tracks, drain pipeline, emit words.
`timescale 1ns / 1ps
`default_nettype none
module mss_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire mss_pkg::stat_t stat_i,
  output mss_pkg::cmd_t      cmd_o
);

  mss_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mss_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && stat_i.scan_req) begin
          state_d = mss_pkg::ST_SCAN;
        end
      end
      mss_pkg::ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.scan_last) begin
          state_d = mss_pkg::ST_FLUSH;
        end
      end
      mss_pkg::ST_FLUSH: begin
        if (!stat_i.pipe_busy) begin
          state_d = mss_pkg::ST_EMIT;
        end
      end
      mss_pkg::ST_EMIT: begin
        if (stat_i.mask_empty) begin
          state_d = mss_pkg::ST_IDLE;
        end else if (stat_i.slot_free) begin
          cmd_o.load = 1'b1;
          if (stat_i.mask_single) begin
            state_d = mss_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = mss_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/mss_dp.sv -----
// Datapath: timing, position, step store, gate compare pipeline, output word.
`timescale 1ns / 1ps
`default_nettype none
module mss_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mss_pkg::cfg_t                 cfg_i,
  input  wire logic                          scnt_wr_i,
  input  wire mss_pkg::cmd_t                 cmd_i,
  output mss_pkg::stat_t                     stat_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [2:0]                    track_index_i,
  input  wire logic [4:0]                    step_index_i,
  input  wire logic [15:0]                   step_value_i,
  input  wire logic [8:0]                    gate_length_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [2:0]                    track_out_o,
  output logic      [15:0]                   control_value_o,
  output logic                               gate_off_o,
  output logic                               last_o
);

  localparam int TRK_W  = mss_pkg::TRK_W;
  localparam int STP_W  = mss_pkg::STP_W;
  localparam int ADDR_W = mss_pkg::ADDR_W;
  localparam int VAL_W  = mss_pkg::VAL_W;
  localparam int LEN_W  = mss_pkg::LEN_W;
  localparam int SPS_W  = mss_pkg::SPS_W;
  localparam int PROD_W = mss_pkg::PROD_W;
  localparam int NTRK   = mss_pkg::MAX_TRACKS;

  // Timing and position state
  logic              started_q;
  logic [SPS_W-1:0]  elapsed_q;
  logic [STP_W-1:0]  pos_q;
  logic              adv_q;
  logic [SPS_W-1:0]  elapsed_inc;
  logic [STP_W-1:0]  pos_next;
  logic [STP_W:0]    pos_plus;
  logic              is_tick;
  logic              is_adv;
  logic              is_write;

  // Store and scan pipeline
  logic [mss_pkg::DEPTH-1:0] valid_q;
  logic [TRK_W-1:0]          scan_trk_q;
  logic [ADDR_W-1:0]         raddr;
  logic [ADDR_W-1:0]         waddr;
  logic [mss_pkg::ENTRY_W-1:0] rdata;
  logic                      s1_v_q;
  logic [TRK_W-1:0]          s1_trk_q;
  logic                      s1_hit_q;
  logic [VAL_W-1:0]          ent_val;
  logic [LEN_W-1:0]          ent_len;
  logic                      s2_v_q;
  logic [TRK_W-1:0]          s2_trk_q;
  logic [VAL_W-1:0]          s2_val_q;
  logic [PROD_W-1:0]         s2_prod_q;
  logic [PROD_W-1:0]         prod_d;
  logic [PROD_W-1:0]         lhs;
  logic                      emit_hit;

  // Result collection
  logic [NTRK-1:0]   mask_q;
  logic [VAL_W-1:0]  vals_q [NTRK];
  logic [TRK_W-1:0]  sel;
  logic [NTRK-1:0]   mask_rest;

  assign is_tick  = (opcode_i == mss_pkg::OP_TICK);
  assign is_adv   = (opcode_i == mss_pkg::OP_ADVANCE);
  assign is_write = (opcode_i == mss_pkg::OP_WRITE);

  // Saturating tick count and wrapped next position
  assign elapsed_inc = (elapsed_q < mss_pkg::ELAPSED_MAX) ? elapsed_q + SPS_W'(1) : elapsed_q;
  assign pos_plus    = {1'b0, pos_q} + (STP_W + 1)'(1);
  assign pos_next    = (pos_plus >= mss_pkg::steps_in_use(cfg_i.step_count)) ? '0
                     : pos_plus[STP_W-1:0];

  // Timing, position and scan mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      elapsed_q <= '0;
      pos_q     <= '0;
      adv_q     <= 1'b0;
    end else if (scnt_wr_i) begin
      pos_q <= '0;
    end else if (cmd_i.accept) begin
      if (is_tick) begin
        if (!started_q) begin
          started_q <= 1'b1;
          elapsed_q <= '0;
        end else if (!cfg_i.external_advance) begin
          if (elapsed_inc >= cfg_i.samples_per_step) begin
            elapsed_q <= '0;
            pos_q     <= pos_next;
            adv_q     <= 1'b1;
          end else begin
            elapsed_q <= elapsed_inc;
            adv_q     <= 1'b0;
          end
        end
      end else if (is_adv) begin
        pos_q <= pos_next;
        adv_q <= 1'b1;
      end
    end
  end

  // Step store: value and length packed in one word
  assign waddr = {track_index_i, step_index_i};
  assign raddr = {scan_trk_q, pos_q};

  mss_ram #(
    .WIDTH (mss_pkg::ENTRY_W),
    .DEPTH (mss_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && is_write),
    .waddr_i (waddr),
    .wdata_i ({step_value_i, gate_length_i}),
    .re_i    (cmd_i.issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Mark written entries; unwritten ones read as the reset contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.accept && is_write) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  // Stage 1: address counter and read tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_trk_q <= '0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        scan_trk_q <= '0;
      end else if (cmd_i.issue) begin
        scan_trk_q <= scan_trk_q + TRK_W'(1);
      end
      s1_v_q <= cmd_i.issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_trk_q <= scan_trk_q;
    s1_hit_q <= valid_q[raddr];
  end

  // Stage 2: gate threshold product
  assign ent_val = s1_hit_q ? rdata[mss_pkg::ENTRY_W-1:LEN_W] : '0;
  assign ent_len = s1_hit_q ? rdata[LEN_W-1:0] : mss_pkg::LEN_RESET;
  assign prod_d  = {{SPS_W{1'b0}}, ent_len} * {{LEN_W{1'b0}}, cfg_i.samples_per_step};

  always_ff @(posedge clk_i) begin
    s2_trk_q  <= s1_trk_q;
    s2_val_q  <= ent_val;
    s2_prod_q <= prod_d;
  end

  // Stage 3: compare elapsed time against the gate
  assign lhs      = {1'b0, elapsed_q, 8'd0};
  assign emit_hit = adv_q || (lhs > s2_prod_q);

  // Pick the lowest pending track
  always_comb begin
    sel = '0;
    for (int i = NTRK - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = TRK_W'(i);
      end
    end
  end
  assign mask_rest = mask_q & ~(NTRK'(1) << sel);

  // Collect results per track, then drop each as it is emitted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cmd_i.accept) begin
      mask_q <= '0;
    end else if (s2_v_q) begin
      mask_q[s2_trk_q] <= emit_hit;
    end else if (cmd_i.load) begin
      mask_q <= mask_rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      vals_q[s2_trk_q] <= adv_q ? s2_val_q : '0;
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      track_out_o     <= sel;
      control_value_o <= vals_q[sel];
      gate_off_o      <= !adv_q;
      last_o          <= (mask_rest == '0);
    end
  end

  // Status to controller
  always_comb begin
    stat_o.scan_req    = (is_tick && started_q && !cfg_i.external_advance) || is_adv;
    stat_o.scan_last   = (scan_trk_q == mss_pkg::last_track(cfg_i.track_count));
    stat_o.pipe_busy   = s1_v_q || s2_v_q;
    stat_o.mask_empty  = (mask_q == '0);
    stat_o.mask_single = (mask_rest == '0);
    stat_o.slot_free   = !out_valid_o || out_ready_i;
  end

endmodule
`default_nettype wire

// ----- rtl/multitrack_step_sequencer.sv -----
// Top level of the multi-track step sequencer.
// Takes one input word at a time. A step write, the first tick after reset
// and a tick in external advance mode finish in the cycle they are accepted.
// A tick or advance that scans the tracks reads the N tracks in use, drains
// the pipeline and then emits the R result words it produces. The time this
// takes is set by the track scan, which reads the shared step store one
// track per cycle and runs each entry through a registered gate multiply and
// compare, and by the output register, which moves one word per cycle while
// the output is not stalled. The next input word is taken while the final
// result still waits at the output.
// The step store needs no clearing pass: per-entry valid bits make unwritten
// entries read as value 0 and half-step gate length right after reset.
`timescale 1ns / 1ps
`default_nettype none
module multitrack_step_sequencer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mss_pkg::APB_AW-1:0]  paddr,
  input  wire logic [mss_pkg::APB_DW-1:0]  pwdata,
  output logic      [mss_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  // Input words
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  opcode_i,
  input  wire logic [2:0]                  track_index_i,
  input  wire logic [4:0]                  step_index_i,
  input  wire logic [15:0]                 step_value_i,
  input  wire logic [8:0]                  gate_length_i,
  // Result words
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [2:0]                  track_out_o,
  output logic      [15:0]                 control_value_o,
  output logic                             gate_off_o,
  output logic                             last_o
);

  mss_pkg::cfg_t  cfg;
  mss_pkg::cmd_t  cmd;
  mss_pkg::stat_t stat;
  logic           scnt_wr;

  mss_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .scnt_wr_o (scnt_wr)
  );

  mss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mss_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .scnt_wr_i       (scnt_wr),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .opcode_i        (opcode_i),
    .track_index_i   (track_index_i),
    .step_index_i    (step_index_i),
    .step_value_i    (step_value_i),
    .gate_length_i   (gate_length_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .track_out_o     (track_out_o),
    .control_value_o (control_value_o),
    .gate_off_o      (gate_off_o),
    .last_o          (last_o)
  );

endmodule
`default_nettype wire

// ----- rtl/mss_chk.sv -----
// Port-level checker of the step sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mss_chk (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        pready,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic [1:0]                  opcode_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [2:0]                  track_out_o,
  input wire logic [15:0]                 control_value_o,
  input wire logic                        gate_off_o,
  input wire logic                        last_o
);

  // A stalled result word holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(track_out_o)
      && $stable(control_value_o) && $stable(gate_off_o) && $stable(last_o))
    else $error("result word changed while stalled");

  // A gate-closing word always carries zero
  a_gate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gate_off_o |-> control_value_o == 16'd0)
    else $error("gate-closing word with nonzero value");

  // A step write never produces a result word
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == mss_pkg::OP_WRITE |=> !$rose(out_valid_o))
    else $error("result word after a step write");

  // An advance always starts a track scan, so input is held off
  a_adv_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == mss_pkg::OP_ADVANCE |=> !in_ready_o)
    else $error("input taken during an advance scan");

  // The configuration port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("configuration port stalled");

endmodule

bind multitrack_step_sequencer mss_chk u_mss_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pready          (pready),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .opcode_i        (opcode_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .track_out_o     (track_out_o),
  .control_value_o (control_value_o),
  .gate_off_o      (gate_off_o),
  .last_o          (last_o)
);
`default_nettype wire
